FILE: rtl/sepq_pkg.sv
// sepq_pkg: shared types and constants for the sorted event priority queue
// used by sepq_ctrl, sepq_datapath and sorted_event_priority_queue
`timescale 1ns / 1ps

package sepq_pkg;

    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TIME_W = 32;
    localparam int TAG_W  = 16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming transaction
        logic exec;   // apply the captured operation to the store
    } t_cmd;

endpackage

FILE: rtl/sepq_ctrl.sv
// sepq_ctrl: handshake and sequencing state machine of the queue
// depends on sepq_pkg
`timescale 1ns / 1ps

module sepq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output sepq_pkg::t_cmd    o_cmd
);

    sepq_pkg::t_state r_state;
    sepq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sepq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sepq_pkg::S_IDLE: begin
                if (i_s_tvalid) n_state = sepq_pkg::S_EXEC;
            end
            sepq_pkg::S_EXEC: begin
                n_state = sepq_pkg::S_DONE;
            end
            sepq_pkg::S_DONE: begin
                // result taken; the next transaction may be accepted in the same cycle
                if (i_m_tready) begin
                    n_state = i_s_tvalid ? sepq_pkg::S_EXEC : sepq_pkg::S_IDLE;
                end
            end
            default: n_state = sepq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            sepq_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
            end
            sepq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            sepq_pkg::S_DONE: begin
                o_m_tvalid = 1'b1;
                o_s_tready = i_m_tready;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
        o_cmd.load = i_s_tvalid && o_s_tready;
    end

endmodule

FILE: rtl/sepq_datapath.sv
// sepq_datapath: sorted shift-register store, insert/remove logic and result registers
// depends on sepq_pkg
`timescale 1ns / 1ps

module sepq_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sepq_pkg::t_cmd                i_cmd,
    input  logic                          i_op,
    input  logic [sepq_pkg::TIME_W-1:0]   i_time,
    input  logic [sepq_pkg::TAG_W-1:0]    i_tag,
    output sepq_pkg::t_status             o_status,
    output logic [sepq_pkg::TIME_W-1:0]   o_time,
    output logic [sepq_pkg::TAG_W-1:0]    o_tag,
    output logic [sepq_pkg::CNT_W-1:0]    o_count
);

    // captured transaction
    sepq_pkg::t_op                   r_op;
    logic [sepq_pkg::TIME_W-1:0]     r_in_time;
    logic [sepq_pkg::TAG_W-1:0]      r_in_tag;

    // sorted store, slot 0 is the head
    logic [sepq_pkg::TIME_W-1:0]     r_time [sepq_pkg::DEPTH];
    logic [sepq_pkg::TAG_W-1:0]      r_tag  [sepq_pkg::DEPTH];
    logic [sepq_pkg::CNT_W-1:0]      r_count;

    sepq_pkg::t_status               r_status;
    logic [sepq_pkg::TIME_W-1:0]     r_out_time;
    logic [sepq_pkg::TAG_W-1:0]      r_out_tag;

    logic                            w_full;
    logic                            w_empty;
    logic                            w_after_head;
    logic [sepq_pkg::DEPTH-1:0]      w_keep;
    logic                            w_do_ins;
    logic                            w_do_rem;

    assign w_full   = (r_count == sepq_pkg::CNT_W'(sepq_pkg::DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_do_ins = i_cmd.exec && (r_op == sepq_pkg::OP_INSERT) && !w_full;
    assign w_do_rem = i_cmd.exec && (r_op == sepq_pkg::OP_REMOVE) && !w_empty;

    // a slot keeps its entry when it lies before the insert position;
    // an equal head time sends the new event to the front
    assign w_after_head = !w_empty && (r_time[0] < r_in_time);

    always_comb begin
        w_keep[0] = w_after_head;
        for (int i = 1; i < sepq_pkg::DEPTH; i++) begin
            w_keep[i] = w_after_head && (sepq_pkg::CNT_W'(i) < r_count)
                        && (r_time[i] <= r_in_time);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= sepq_pkg::t_op'(i_op);
            r_in_time <= i_time;
            r_in_tag  <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_ins) begin
            if (!w_keep[0]) begin
                r_time[0] <= r_in_time;
                r_tag[0]  <= r_in_tag;
            end
            for (int i = 1; i < sepq_pkg::DEPTH; i++) begin
                if (!w_keep[i]) begin
                    if (w_keep[i-1]) begin
                        r_time[i] <= r_in_time;
                        r_tag[i]  <= r_in_tag;
                    end else begin
                        r_time[i] <= r_time[i-1];
                        r_tag[i]  <= r_tag[i-1];
                    end
                end
            end
        end else if (w_do_rem) begin
            for (int i = 0; i < sepq_pkg::DEPTH - 1; i++) begin
                r_time[i] <= r_time[i+1];
                r_tag[i]  <= r_tag[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_do_ins) begin
            r_count <= r_count + 1'b1;
        end else if (w_do_rem) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_time <= '0;
            r_out_tag  <= '0;
            r_status   <= sepq_pkg::ST_OK;
            if (r_op == sepq_pkg::OP_INSERT) begin
                if (w_full) r_status <= sepq_pkg::ST_FULL;
            end else if (w_empty) begin
                r_status <= sepq_pkg::ST_EMPTY;
            end else begin
                r_out_time <= r_time[0];
                r_out_tag  <= r_tag[0];
            end
        end
    end

    assign o_status = r_status;
    assign o_time   = r_out_time;
    assign o_tag    = r_out_tag;
    assign o_count  = r_count;

endmodule

FILE: rtl/sorted_event_priority_queue.sv
// sorted_event_priority_queue: top level, stream ports around controller and datapath
// depends on sepq_pkg, sepq_ctrl, sepq_datapath
//
//   channel  direction  ports                  contents
//   s_*      in         tvalid tready tdata    tdata[47:0] = event_time, event_tag
//                       tuser                  tuser = operation
//   m_*      out        tvalid tready tdata    tdata[54:0] = out_time, out_tag, occupancy
//                       tuser                  tuser = status
//
// each transaction is first captured, then in the exec state the whole store
// compares against the new time in parallel and shifts one slot up or down.
// the result is held on m_* until taken; the next transaction is accepted in the
// cycle the result leaves, so a stalled output stalls the input.
// synchronous active-low reset empties the queue; the store itself is not cleared.
`timescale 1ns / 1ps

module sorted_event_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // event_time[31:0], event_tag[47:32]
    input  logic        i_s_tuser,   // operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // out_time[31:0], out_tag[47:32], occupancy[54:48], zero
    output logic [1:0]  o_m_tuser    // status
);

    sepq_pkg::t_cmd                  w_cmd;
    sepq_pkg::t_status               w_status;
    logic [sepq_pkg::TIME_W-1:0]     w_time;
    logic [sepq_pkg::TAG_W-1:0]      w_tag;
    logic [sepq_pkg::CNT_W-1:0]      w_count;

    sepq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    sepq_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_op     (i_s_tuser),
        .i_time   (i_s_tdata[31:0]),
        .i_tag    (i_s_tdata[47:32]),
        .o_status (w_status),
        .o_time   (w_time),
        .o_tag    (w_tag),
        .o_count  (w_count)
    );

    assign o_m_tdata = {1'b0, w_count, w_tag, w_time};
    assign o_m_tuser = w_status;

endmodule
